### design/bcjd_pkg.sv
// Package for the x86 branch/call decode filter.
// Holds the opcode constants, the small decision tables and the queue entry type.
// No dependencies.
package bcjd_pkg;

  // Opcode match: E8 (call) and E9 (jmp) share all bits but the lowest.
  localparam logic [7:0] OPC_MASK = 8'hFE;
  localparam logic [7:0] OPC_CALL = 8'hE8;
  localparam logic [7:0] MSB_ONES = 8'hFF;
  localparam logic [2:0] MASK3    = 3'h7;

  // Distance value that means "far from the last candidate".
  localparam logic [2:0] FAR_DIST = 3'd4;

  // Index of the last refinement pass on the target; passes count from zero.
  localparam logic [1:0] LAST_PASS = 2'd3;

  // Whether a recent-opcode mask still allows a conversion, indexed by the mask.
  localparam logic [7:0] ALLOWED_TAB = 8'b0001_0111;

  // Which operand byte, counted from the top, the mask points at.
  localparam logic [1:0] BITNUM_TAB [8] = '{2'd0, 2'd1, 2'd2, 2'd2,
                                            2'd3, 2'd3, 2'd3, 2'd3};

  // Number of bytes held from input to decision: four lookahead plus the current one.
  localparam int unsigned BUF_DEPTH = 5;

  // One queue entry: up to five restored bytes, lowest index leaves first.
  typedef struct packed {
    logic [4:0][7:0] bytes;
    logic [2:0]      count;
    logic            last;
  } bcjd_entry_t;

  // A top byte of 00 or FF marks a plausible near target.
  function automatic logic ms_byte_ok(input logic [7:0] b);
    ms_byte_ok = (b == 8'h00) || (b == MSB_ONES);
  endfunction

endpackage

### design/bcjd_front.sv
// Front part of the decode filter: takes bytes, keeps the lookahead window and
// decides on each candidate, converting targets over one to four passes.
// Depends on bcjd_pkg; feeds finished groups of bytes into bcjd_queue.
module bcjd_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [7:0]           data_byte,
  input  logic                 end_of_buffer,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 push,
  output bcjd_pkg::bcjd_entry_t push_entry,
  input  logic                 queue_full
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_DECIDE = 4'b0010,
    S_REFINE = 4'b0100,
    S_PUSH   = 4'b1000
  } state_t;

  state_t      state;
  logic [7:0]  buf_q [bcjd_pkg::BUF_DEPTH];
  logic [2:0]  fill;
  logic [2:0]  n_held;
  logic        last_r;
  logic [2:0]  used;
  logic [31:0] pos;
  logic [31:0] pos5;
  logic [31:0] src;
  logic [2:0]  mark_dist;
  logic [2:0]  rmask;
  logic [1:0]  pass;
  logic [1:0]  sel;

  // Decision on the oldest byte.
  logic        is_op;
  logic [2:0]  m_shift;
  logic [1:0]  bn;
  logic [2:0]  rej_idx;
  logic        early_reject;
  logic        top_ok;
  logic [2:0]  dist_inc;

  // Refinement pass.
  logic [31:0] dest;
  logic [7:0]  chk_byte;
  logic        refine_stop;
  logic [31:0] src_next;

  // Push side.
  logic [2:0]  emit_count;

  assign in_ready = (state == S_IDLE);

  // Recent-opcode mask aged by the distance to the last rejected candidate.
  always_comb begin
    is_op = (buf_q[0] & bcjd_pkg::OPC_MASK) == bcjd_pkg::OPC_CALL;
    case (mark_dist)
      3'd1:    m_shift = rmask;
      3'd2:    m_shift = {rmask[1:0], 1'b0} & bcjd_pkg::MASK3;
      3'd3:    m_shift = {rmask[0], 2'b00} & bcjd_pkg::MASK3;
      default: m_shift = 3'd0;
    endcase
    bn           = bcjd_pkg::BITNUM_TAB[m_shift];
    rej_idx      = 3'd4 - {1'b0, bn};
    early_reject = (m_shift != 3'd0) &&
                   (!bcjd_pkg::ALLOWED_TAB[m_shift] ||
                    bcjd_pkg::ms_byte_ok(buf_q[rej_idx]));
    top_ok       = bcjd_pkg::ms_byte_ok(buf_q[4]);
    dist_inc     = (mark_dist >= 3'd3) ? bcjd_pkg::FAR_DIST : mark_dist + 3'd1;
  end

  // One refinement pass: subtract, test the selected byte, flip the low bits.
  always_comb begin
    dest = src - pos5;
    case (sel)
      2'd1: begin
        chk_byte = dest[23:16];
        src_next = {dest[31:24], ~dest[23:0]};
      end
      2'd2: begin
        chk_byte = dest[15:8];
        src_next = {dest[31:16], ~dest[15:0]};
      end
      2'd3: begin
        chk_byte = dest[7:0];
        src_next = {dest[31:8], ~dest[7:0]};
      end
      default: begin
        chk_byte = dest[31:24];
        src_next = dest;
      end
    endcase
    refine_stop = (rmask == 3'd0) || (pass == bcjd_pkg::LAST_PASS) ||
                  !bcjd_pkg::ms_byte_ok(chk_byte);
  end

  // Bytes that leave with this item: all of them at the end of a buffer.
  always_comb begin
    if (last_r) begin
      emit_count = n_held;
    end else if (n_held == 3'd5) begin
      emit_count = used;
    end else begin
      emit_count = 3'd0;
    end
    for (int i = 0; i < 5; i++) begin
      push_entry.bytes[i] = buf_q[i];
    end
    push_entry.count = emit_count;
    push_entry.last  = last_r;
    push = (state == S_PUSH) && (emit_count != 3'd0) && !queue_full;
  end

  // Control sequence and window bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill      <= 3'd0;
      pos       <= 32'd0;
      mark_dist <= bcjd_pkg::FAR_DIST;
      rmask     <= 3'd0;
      n_held    <= 3'd0;
      last_r    <= 1'b0;
      used      <= 3'd1;
      pass      <= 2'd0;
      sel       <= 2'd0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            buf_q[fill] <= data_byte;
            n_held      <= fill + 3'd1;
            last_r      <= end_of_buffer;
            used        <= 3'd1;
            state       <= (fill == 3'd4) ? S_DECIDE : S_PUSH;
          end
        end
        S_DECIDE: begin
          if (!is_op) begin
            mark_dist <= dist_inc;
            state     <= S_PUSH;
          end else if (early_reject || !top_ok) begin
            rmask     <= {m_shift[1:0], 1'b1};
            mark_dist <= 3'd1;
            state     <= S_PUSH;
          end else begin
            rmask     <= m_shift;
            sel       <= bn;
            mark_dist <= bcjd_pkg::FAR_DIST;
            used      <= 3'd5;
            src       <= {buf_q[4], buf_q[3], buf_q[2], buf_q[1]};
            pos5      <= pos + 32'd5;
            pass      <= 2'd0;
            state     <= S_REFINE;
          end
        end
        S_REFINE: begin
          if (refine_stop) begin
            buf_q[4] <= dest[24] ? bcjd_pkg::MSB_ONES : 8'h00;
            buf_q[3] <= dest[23:16];
            buf_q[2] <= dest[15:8];
            buf_q[1] <= dest[7:0];
            state    <= S_PUSH;
          end else begin
            src  <= src_next;
            pass <= pass + 2'd1;
          end
        end
        S_PUSH: begin
          if (emit_count == 3'd0 || !queue_full) begin
            state <= S_IDLE;
            if (last_r) begin
              fill      <= 3'd0;
              pos       <= 32'd0;
              mark_dist <= bcjd_pkg::FAR_DIST;
              rmask     <= 3'd0;
            end else if (n_held == 3'd5) begin
              pos <= pos + {29'd0, used};
              if (used == 3'd5) begin
                fill <= 3'd0;
              end else begin
                for (int i = 0; i < 4; i++) begin
                  buf_q[i] <= buf_q[i + 1];
                end
                fill <= 3'd4;
              end
            end else begin
              fill <= n_held;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The window never holds more than four bytes between items.
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (fill <= 3'd4))
    else $error("lookahead window overfilled");

  // The last refinement pass always ends the conversion.
  a_pass_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_REFINE && pass == bcjd_pkg::LAST_PASS) |=> (state == S_PUSH))
    else $error("refinement ran past its last pass");

endmodule

### design/bcjd_queue.sv
// Short queue of byte groups between the front and back parts of the filter.
// Depends on bcjd_pkg for the entry type.
module bcjd_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  bcjd_pkg::bcjd_entry_t push_entry,
  output logic                  full,
  input  logic                  pop,
  output logic                  head_valid,
  output bcjd_pkg::bcjd_entry_t head
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  bcjd_pkg::bcjd_entry_t entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_pop;

  assign full       = (count == CNT_FULL);
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];
  assign do_pop     = pop && head_valid;

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push && !full) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  // Pointers and occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if ((push && !full) && !do_pop) begin
        count <= count + 1'b1;
      end else if (!(push && !full) && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

  // The front never offers a group while the queue is full.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("push into a full queue");

endmodule

### design/bcjd_back.sv
// Back part of the decode filter: sends the bytes of each queued group one per
// transaction. Depends on bcjd_pkg for the entry type.
module bcjd_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  head_valid,
  input  bcjd_pkg::bcjd_entry_t head,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            out_byte,
  output logic                  out_last
);

  logic [2:0] idx;
  logic       at_end;

  // Current byte of the head group.
  always_comb begin
    at_end    = (idx == head.count - 3'd1);
    out_valid = head_valid;
    out_byte  = head.bytes[idx];
    out_last  = head.last && at_end;
    pop       = head_valid && out_ready && at_end;
  end

  // Byte index within the group.
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= 3'd0;
    end else if (head_valid && out_ready) begin
      idx <= at_end ? 3'd0 : idx + 3'd1;
    end
  end

  // The index stays inside the group being sent.
  a_idx_in_group: assert property (@(posedge clk) disable iff (rst)
    head_valid |-> (idx < head.count))
    else $error("byte index beyond group");

endmodule

### design/x86_branch_call_decode_filter_unit.sv
// Top level of the x86 branch/call decode filter.
// Instantiates bcjd_front, bcjd_queue and bcjd_back; uses bcjd_pkg.
//
// Restores a buffer that went through the x86 call/jump filter, one byte per
// input transaction. Four bytes are held back as lookahead, so output trails
// input; an E8/E9 whose operand converts leaves as five bytes together, and
// the transaction with s_axis_tlast flushes the held bytes (the final one with
// m_axis_tlast) and clears all state for the next buffer. The front part takes
// a byte through the idle and push states while the window fills, adds the
// decide state once the oldest byte is decided, and one to four refinement
// passes of the 32-bit subtractor when a target is converted, waiting on a
// full queue. The back part sends one byte per cycle while a group is queued
// and m_axis_tready is high, and the queue between them, QUEUE_DEPTH groups
// deep, lets each side stall without holding up the other.
module x86_branch_call_decode_filter_unit #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
  input  logic       s_axis_tlast,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic       m_axis_tlast
);

  logic                  push;
  bcjd_pkg::bcjd_entry_t push_entry;
  logic                  queue_full;
  logic                  pop;
  logic                  head_valid;
  bcjd_pkg::bcjd_entry_t head;

  // Window, decision and target conversion.
  bcjd_front u_front (
    .clk           (clk),
    .rst           (rst),
    .data_byte     (s_axis_tdata),
    .end_of_buffer (s_axis_tlast),
    .in_valid      (s_axis_tvalid),
    .in_ready      (s_axis_tready),
    .push          (push),
    .push_entry    (push_entry),
    .queue_full    (queue_full)
  );

  // Groups of restored bytes waiting to be sent.
  bcjd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  // Byte-by-byte output.
  bcjd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_byte   (m_axis_tdata),
    .out_last   (m_axis_tlast)
  );

endmodule
